/* hdl/mifd_pkg.sv */
// shared types and constants for the motor / imu frame decoder
// no dependencies; imported by mifd_ctrl, mifd_dp and the top level
`default_nettype none

package mifd_pkg;

   // defaults for the top level parameters
   localparam int MOTORS_DEF      = 4;
   localparam int IMUS_DEF        = 6;
   localparam int STORE_DEPTH_DEF = 64;

   // frame layout
   localparam int CTRL_BYTES    = 4;
   localparam int MOTOR_BYTES   = 5;
   localparam int IMU_BYTES     = 10;
   localparam int HEAD_MOTORS   = 2;
   localparam int MASK_W        = 4;
   localparam int IMU_UNIT_BASE = 4;

   // gather register holds the widest per-unit record
   localparam int GATHER_W = 8 * IMU_BYTES;
   localparam int FLEN_W   = 4;
   localparam int UIDX_W   = 3;

   localparam logic [6:0] VEL_MAX     = 7'd100;
   localparam logic [6:0] VEL_DEFAULT = 7'd50;

   // configuration register indexes
   localparam logic [1:0] CFG_MOTOR_START = 2'd0;
   localparam logic [1:0] CFG_IMU_START   = 2'd1;
   localparam logic [1:0] CFG_ALLOW_MASK  = 2'd2;

   localparam logic [7:0] MOTOR_START_RST = 8'd0;
   localparam logic [7:0] IMU_START_RST   = 8'd1;
   localparam logic [3:0] ALLOW_MASK_RST  = 4'd2;

   typedef struct packed {
      logic              count_clr;
      logic              store_wr;
      logic              is_motor;
      logic              fetch_start;
      logic [FLEN_W-1:0] fetch_len;
      logic              ctrl_latch;
      logic              result_load;
      logic [UIDX_W-1:0] unit_idx;
      logic              unit_last;
   } dp_cmd_type;

   typedef struct packed {
      logic hit_motor;
      logic hit_imu;
      logic store_full;
      logic frame_done;
      logic fetch_done;
   } dp_status_type;

endpackage

`default_nettype wire

/* hdl/mifd_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module mifd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/mifd_ctrl.sv */
// frame controller: start byte hunt, payload collect, per-unit fetch and send
// depends on mifd_pkg
`default_nettype none

module mifd_ctrl
   import mifd_pkg::*;
#(
   parameter int MOTORS = MOTORS_DEF,
   parameter int IMUS   = IMUS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_HUNT    = 5'b00001,
      ST_COLLECT = 5'b00010,
      ST_CFETCH  = 5'b00100,
      ST_UFETCH  = 5'b01000,
      ST_SEND    = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic              is_motor_ff, is_motor_in;
   logic [UIDX_W-1:0] unit_idx_ff, unit_idx_in;
   logic              req_accept;
   logic              unit_last;

   assign req_ready  = (state_ff == ST_HUNT) || (state_ff == ST_COLLECT);
   assign rsp_valid  = (state_ff == ST_SEND);
   assign req_accept = req_valid && req_ready;
   assign unit_last  = is_motor_ff ? (unit_idx_ff == UIDX_W'(MOTORS - 1))
                                   : (unit_idx_ff == UIDX_W'(IMUS - 1));

   always_comb begin
      state_in        = state_ff;
      is_motor_in     = is_motor_ff;
      unit_idx_in     = unit_idx_ff;
      cmd             = '0;
      cmd.is_motor    = is_motor_ff;
      cmd.unit_idx    = unit_idx_ff;
      cmd.unit_last   = unit_last;
      case (state_ff)
         ST_HUNT: begin
            if (req_accept && (status.hit_motor || status.hit_imu)) begin
               is_motor_in   = status.hit_motor;
               cmd.count_clr = 1'b1;
               state_in      = ST_COLLECT;
            end
         end
         ST_COLLECT: begin
            if (req_accept) begin
               if (status.store_full) begin
                  cmd.count_clr = 1'b1;
                  state_in      = ST_HUNT;
               end else begin
                  cmd.store_wr = 1'b1;
                  if (status.frame_done) begin
                     unit_idx_in     = '0;
                     cmd.fetch_start = 1'b1;
                     if (is_motor_ff) begin
                        cmd.fetch_len = FLEN_W'(CTRL_BYTES);
                        state_in      = ST_CFETCH;
                     end else begin
                        cmd.fetch_len = FLEN_W'(IMU_BYTES);
                        state_in      = ST_UFETCH;
                     end
                  end
               end
            end
         end
         ST_CFETCH: begin
            if (status.fetch_done) begin
               cmd.ctrl_latch  = 1'b1;
               cmd.fetch_start = 1'b1;
               cmd.fetch_len   = FLEN_W'(MOTOR_BYTES);
               state_in        = ST_UFETCH;
            end
         end
         ST_UFETCH: begin
            if (status.fetch_done) begin
               cmd.result_load = 1'b1;
               state_in        = ST_SEND;
            end
         end
         ST_SEND: begin
            if (rsp_ready) begin
               if (unit_last) begin
                  cmd.count_clr = 1'b1;
                  state_in      = ST_HUNT;
               end else begin
                  unit_idx_in     = unit_idx_ff + UIDX_W'(1);
                  cmd.fetch_start = 1'b1;
                  cmd.fetch_len   = is_motor_ff ? FLEN_W'(MOTOR_BYTES)
                                                : FLEN_W'(IMU_BYTES);
                  state_in        = ST_UFETCH;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_HUNT;
         is_motor_ff <= 1'b0;
         unit_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         is_motor_ff <= is_motor_in;
         unit_idx_ff <= unit_idx_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/mifd_dp.sv */
// datapath: config registers, payload store, byte gather and result registers
// depends on mifd_pkg and mifd_ram
`default_nettype none

module mifd_dp
   import mifd_pkg::*;
#(
   parameter int MOTORS      = MOTORS_DEF,
   parameter int IMUS        = IMUS_DEF,
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [7:0]    rx_byte,
   input  wire logic          csr_wr,
   input  wire logic [1:0]    csr_index,
   input  wire logic [7:0]    csr_data,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   output logic [3:0]         unit,
   output logic               enable,
   output logic               direction,
   output logic               angle_mode,
   output logic               angle_update,
   output logic [31:0]        angle_bits,
   output logic [6:0]         velocity,
   output logic signed [15:0] accel_x,
   output logic signed [15:0] accel_y,
   output logic signed [15:0] accel_z,
   output logic [31:0]        timestamp_ms,
   output logic               last
);

   localparam int ADDR_W    = $clog2(STORE_DEPTH);
   localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int MOTOR_LEN = CTRL_BYTES + MOTOR_BYTES * MOTORS;
   localparam int IMU_LEN   = IMU_BYTES * IMUS;

   logic [7:0]          motor_start_ff, imu_start_ff;
   logic [MASK_W-1:0]   allow_mask_ff;
   logic [CNT_W-1:0]    byte_count_ff;
   logic [ADDR_W-1:0]   rd_addr_ff;
   logic [FLEN_W-1:0]   fetch_left_ff;
   logic                rd_pend_ff;
   logic [GATHER_W-1:0] gather_ff;
   logic [31:0]         control_ff;
   logic [7:0]          rd_data;
   logic                rd_en;
   logic [CNT_W-1:0]    count_next;

   // result registers
   logic [3:0]          unit_ff;
   logic                enable_ff, direction_ff, angle_mode_ff, angle_update_ff;
   logic [31:0]         angle_bits_ff;
   logic [6:0]          velocity_ff;
   logic signed [15:0]  accel_x_ff, accel_y_ff, accel_z_ff;
   logic [31:0]         timestamp_ms_ff;
   logic                last_ff;

   // result build
   logic [3:0]  nib;
   logic        allowed, head;
   logic [7:0]  vel_byte;
   logic [6:0]  vel_clamp;
   logic        m_en, m_dir, m_mode, m_upd;
   logic [31:0] m_ang;
   logic [6:0]  m_vel;

   mifd_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.store_wr),
      .wr_addr(byte_count_ff[ADDR_W-1:0]),
      .wr_data(rx_byte),
      .rd_en  (rd_en),
      .rd_addr(rd_addr_ff),
      .rd_data(rd_data)
   );

   assign rd_en      = (fetch_left_ff != '0);
   assign count_next = byte_count_ff + CNT_W'(1);

   assign unit         = unit_ff;
   assign enable       = enable_ff;
   assign direction    = direction_ff;
   assign angle_mode   = angle_mode_ff;
   assign angle_update = angle_update_ff;
   assign angle_bits   = angle_bits_ff;
   assign velocity     = velocity_ff;
   assign accel_x      = accel_x_ff;
   assign accel_y      = accel_y_ff;
   assign accel_z      = accel_z_ff;
   assign timestamp_ms = timestamp_ms_ff;
   assign last         = last_ff;

   always_comb begin
      status.hit_motor  = (rx_byte == motor_start_ff);
      status.hit_imu    = (rx_byte == imu_start_ff);
      status.store_full = (byte_count_ff == CNT_W'(STORE_DEPTH));
      status.frame_done = cmd.is_motor ? (count_next == CNT_W'(MOTOR_LEN))
                                       : (count_next == CNT_W'(IMU_LEN));
      status.fetch_done = (fetch_left_ff == '0) && !rd_pend_ff;
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         motor_start_ff <= MOTOR_START_RST;
         imu_start_ff   <= IMU_START_RST;
         allow_mask_ff  <= ALLOW_MASK_RST;
      end else if (csr_wr) begin
         case (csr_index)
            CFG_MOTOR_START: motor_start_ff <= csr_data;
            CFG_IMU_START:   imu_start_ff   <= csr_data;
            CFG_ALLOW_MASK:  allow_mask_ff  <= csr_data[MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // byte counter and read sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         rd_addr_ff    <= '0;
         fetch_left_ff <= '0;
         rd_pend_ff    <= 1'b0;
      end else begin
         rd_pend_ff <= rd_en;
         if (cmd.count_clr) begin
            byte_count_ff <= '0;
            rd_addr_ff    <= '0;
         end else begin
            if (cmd.store_wr) begin
               byte_count_ff <= count_next;
            end
            if (rd_en) begin
               rd_addr_ff <= rd_addr_ff + ADDR_W'(1);
            end
         end
         if (cmd.fetch_start) begin
            fetch_left_ff <= cmd.fetch_len;
         end else if (rd_en) begin
            fetch_left_ff <= fetch_left_ff - FLEN_W'(1);
         end
      end
   end

   // bytes enter at the top, so a record of n bytes ends up in the top n bytes
   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         gather_ff <= {rd_data, gather_ff[GATHER_W-1:8]};
      end
      if (cmd.ctrl_latch) begin
         control_ff <= gather_ff[GATHER_W-1 -: 32];
      end
   end

   always_comb begin
      nib       = control_ff[4*cmd.unit_idx +: 4];
      allowed   = (cmd.unit_idx < UIDX_W'(MASK_W))
                  && allow_mask_ff[cmd.unit_idx[$clog2(MASK_W)-1:0]];
      head      = (cmd.unit_idx < UIDX_W'(HEAD_MOTORS));
      vel_byte  = gather_ff[GATHER_W-1 -: 8];
      vel_clamp = (vel_byte > {1'b0, VEL_MAX}) ? VEL_MAX : vel_byte[6:0];
      m_en      = 1'b0;
      m_dir     = 1'b0;
      m_mode    = !head;
      m_upd     = 1'b0;
      m_ang     = '0;
      m_vel     = '0;
      if (allowed) begin
         m_en  = nib[0];
         m_dir = nib[1];
         if (nib[2]) begin
            m_mode = 1'b1;
            m_upd  = 1'b1;
            m_ang  = gather_ff[GATHER_W-9 -: 32];
            m_vel  = nib[3] ? vel_clamp : VEL_DEFAULT;
         end else if (head && nib[3]) begin
            m_vel = vel_clamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         last_ff <= cmd.unit_last;
         if (cmd.is_motor) begin
            unit_ff         <= 4'(cmd.unit_idx);
            enable_ff       <= m_en;
            direction_ff    <= m_dir;
            angle_mode_ff   <= m_mode;
            angle_update_ff <= m_upd;
            angle_bits_ff   <= m_ang;
            velocity_ff     <= m_vel;
            accel_x_ff      <= '0;
            accel_y_ff      <= '0;
            accel_z_ff      <= '0;
            timestamp_ms_ff <= '0;
         end else begin
            unit_ff         <= 4'(IMU_UNIT_BASE) + 4'(cmd.unit_idx);
            enable_ff       <= 1'b0;
            direction_ff    <= 1'b0;
            angle_mode_ff   <= 1'b0;
            angle_update_ff <= 1'b0;
            angle_bits_ff   <= '0;
            velocity_ff     <= '0;
            accel_x_ff      <= gather_ff[15:0];
            accel_y_ff      <= gather_ff[31:16];
            accel_z_ff      <= gather_ff[47:32];
            timestamp_ms_ff <= gather_ff[79:48];
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/motor_imu_frame_decoder_core.sv */
// top level of the motor / imu serial frame decoder
// depends on mifd_pkg, mifd_ctrl, mifd_dp and mifd_ram
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | req_rx_byte
//   rsp     | out       | rsp_valid/ready    | unit, motor command, imu sample, last
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// a byte is taken every cycle while hunting for a start byte or collecting payload
// the final payload byte starts readback from the store: one byte a cycle; a motor frame
// first fetches its control word, then every record is fetched and then offered on rsp,
// and an rsp stall holds the fetch of the next record
// req_ready is low during readback
// reset returns to the hunt state and loads the register defaults; csr_ready is always high
`default_nettype none

module motor_imu_frame_decoder_core
   import mifd_pkg::*;
#(
   parameter int MOTORS      = MOTORS_DEF,
   parameter int IMUS        = IMUS_DEF,
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [3:0]              rsp_unit,
   output logic                    rsp_enable,
   output logic                    rsp_direction,
   output logic                    rsp_angle_mode,
   output logic                    rsp_angle_update,
   output logic [31:0]             rsp_angle_bits,
   output logic [6:0]              rsp_velocity,
   output logic signed [15:0]      rsp_accel_x,
   output logic signed [15:0]      rsp_accel_y,
   output logic signed [15:0]      rsp_accel_z,
   output logic [31:0]             rsp_timestamp_ms,
   output logic                    rsp_last,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [7:0]         csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   mifd_ctrl #(
      .MOTORS(MOTORS),
      .IMUS  (IMUS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   mifd_dp #(
      .MOTORS     (MOTORS),
      .IMUS       (IMUS),
      .STORE_DEPTH(STORE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .rx_byte     (req_rx_byte),
      .csr_wr      (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .unit        (rsp_unit),
      .enable      (rsp_enable),
      .direction   (rsp_direction),
      .angle_mode  (rsp_angle_mode),
      .angle_update(rsp_angle_update),
      .angle_bits  (rsp_angle_bits),
      .velocity    (rsp_velocity),
      .accel_x     (rsp_accel_x),
      .accel_y     (rsp_accel_y),
      .accel_z     (rsp_accel_z),
      .timestamp_ms(rsp_timestamp_ms),
      .last        (rsp_last)
   );

   // input side is closed while a result is offered on rsp
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input open while a result is pending");

   a_resume_hunt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> (req_ready && !rsp_valid))
      else $error("decoder did not return to hunt after last item");

   a_angle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_angle_update) |-> (rsp_angle_bits == '0))
      else $error("angle bits set without angle update");

   a_vel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_velocity <= VEL_MAX))
      else $error("velocity above clamp");

endmodule

`default_nettype wire
